>>> design/region_pool_allocator_defines.svh
// assertion macros for the region pool allocator
`ifndef REGION_POOL_ALLOCATOR_DEFINES_SVH
`define REGION_POOL_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("rpa check failed");
`define RPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("rpa check failed");
`else
`define RPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/rpa_pkg.sv
// types and constants shared by the region pool allocator
package rpa_pkg;
	localparam int NUM_REGIONS = 64;
	localparam int COUNTER_BITS = 32;
	localparam int IDX_W = 6;
	localparam int CNT7_W = 7;
	localparam int STAT_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REGIONS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COOLS = 1'b1;
	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		OUT_WARM_HIT = 3'd0,
		OUT_COLD_HIT = 3'd1,
		OUT_NEW = 3'd2,
		OUT_EXHAUSTED = 3'd3,
		OUT_RELEASED = 3'd4,
		OUT_REJECTED = 3'd5
	} outcome_t;

	typedef struct packed {
		logic req_type;
		logic [IDX_W-1:0] region_index;
		logic allow_release;
	} req_t;

	typedef struct packed {
		logic granted;
		logic [IDX_W-1:0] granted_index;
		logic [2:0] outcome;
		logic [CNT7_W-1:0] reserved_count;
		logic [CNT7_W-1:0] free_count;
		logic [STAT_W-1:0] new_alloc_total;
		logic [STAT_W-1:0] warm_hit_total;
		logic [STAT_W-1:0] cold_hit_total;
		logic [STAT_W-1:0] cooled_total;
		logic [STAT_W-1:0] exhausted_total;
	} result_t;

	// commands broadcast to every cell of the free list chain
	typedef struct packed {
		logic append;
		logic rotate;
		logic remove_head;
	} chain_ctl_t;
endpackage

>>> design/rpa_cell.sv
// one slot of the free list chain: region handle and its warm bit
module rpa_cell #(
	parameter int IW = 6
) (
	input logic clk,
	input logic arst_n,
	input rpa_pkg::chain_ctl_t ctl,
	input logic is_tail_slot,
	input logic [IW-1:0] app_index,
	input logic app_warm,
	input logic [IW-1:0] nxt_index,
	input logic nxt_warm,
	input logic nxt_valid,
	input logic [IW-1:0] head_index,
	input logic head_warm,
	input logic rot_is_last,
	output logic [IW-1:0] index_q,
	output logic warm_q,
	output logic valid_q
);
	// rotate moves the head to the back slot; remove shifts everything up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.remove_head) begin
			valid_q <= nxt_valid;
		end else if (ctl.append && is_tail_slot) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.remove_head) begin
			index_q <= nxt_index;
			warm_q <= nxt_warm;
		end else if (ctl.rotate) begin
			if (rot_is_last) begin
				index_q <= head_index;
				warm_q <= head_warm;
			end else begin
				index_q <= nxt_index;
				warm_q <= nxt_warm;
			end
		end else if (ctl.append && is_tail_slot) begin
			index_q <= app_index;
			warm_q <= app_warm;
		end
	end
endmodule

>>> design/rpa_chain.sv
// row of free list cells with head access for a rotating warm search
module rpa_chain #(
	parameter int N = 64,
	parameter int IW = 6,
	parameter int LW = 7
) (
	input logic clk,
	input logic arst_n,
	input rpa_pkg::chain_ctl_t ctl,
	input logic [LW-1:0] len,
	input logic [IW-1:0] app_index,
	input logic app_warm,
	output logic [IW-1:0] head_index,
	output logic head_warm
);
	logic [IW-1:0] idx [N];
	logic warm [N];
	logic vld [N];

	assign head_index = idx[0];
	assign head_warm = warm[0];

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [IW-1:0] ni;
		logic nw, nv;
		if (g == N - 1) begin : g_end
			assign ni = idx[g];
			assign nw = 1'b0;
			assign nv = 1'b0;
		end else begin : g_mid
			assign ni = idx[g+1];
			assign nw = warm[g+1];
			assign nv = vld[g+1];
		end
		rpa_cell #(.IW(IW)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.is_tail_slot(len == LW'(g)),
			.app_index(app_index),
			.app_warm(app_warm),
			.nxt_index(ni),
			.nxt_warm(nw),
			.nxt_valid(nv),
			.head_index(idx[0]),
			.head_warm(warm[0]),
			.rot_is_last(len == LW'(g + 1)),
			.index_q(idx[g]),
			.warm_q(warm[g]),
			.valid_q(vld[g])
		);
	end
endmodule

>>> design/region_pool_allocator.sv
// region pool allocator top level: control, counters and free list chain
// Usage: pulse start with req while busy is low. An acquire takes the oldest
// warm free region, else the oldest cold one, else creates a region, else
// reports exhaustion. A release appends the region to the free list, or is
// rejected if unreserved, already free or the list is full. The free list is
// a chain of cells; the acquire search rotates the list one slot per cycle,
// looking at the head cell. With no warm entry the list turns once fully and
// the head, then the oldest again, is taken. A release or an acquire with an
// empty list goes from decide to done; an acquire over a non-empty list
// searches, then rotates the remainder back into order before done.
// busy is high from acceptance until the result strobe; one request at a time.
// result_valid is high for one cycle with result; the receiver cannot stall.
// Configuration writes on cfg_valid/cfg_ready (always ready); write only
// while idle. Reset empties the free list, clears counters, max_regions=64,
// release_cools=1. The warm flag store needs no clearing pass.
module region_pool_allocator (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input rpa_pkg::req_t req,
	output logic result_valid,
	output rpa_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data
);
	`include "region_pool_allocator_defines.svh"
	localparam int NUM_REGIONS = rpa_pkg::NUM_REGIONS;
	localparam int COUNTER_BITS = rpa_pkg::COUNTER_BITS;
	localparam int IW = rpa_pkg::IDX_W;
	localparam int LW = rpa_pkg::CNT7_W;
	localparam int SW = rpa_pkg::STAT_W;
	localparam logic [COUNTER_BITS-1:0] CMAX = '1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_SEARCH = 5'b00100,
		ST_REALIGN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;
	rpa_pkg::req_t req_q;
	logic [LW-1:0] max_q, len_q, resv_q, step_q, rem_q;
	logic cools_q;
	logic [NUM_REGIONS-1:0] free_q;
	logic [COUNTER_BITS-1:0] c_new_q, c_warm_q, c_cold_q, c_cool_q, c_exh_q;
	logic granted_q;
	logic [IW-1:0] gidx_q;
	rpa_pkg::outcome_t out_q;
	rpa_pkg::chain_ctl_t ctl;
	logic [IW-1:0] head_index;
	logic head_warm;
	logic rel_ok, can_new;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign rel_ok = (LW'(req_q.region_index) < resv_q) && !free_q[req_q.region_index]
		&& (len_q < LW'(NUM_REGIONS));
	assign can_new = (resv_q < max_q) && (resv_q < LW'(NUM_REGIONS));

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_DECIDE: ctl.append = (req_q.req_type == rpa_pkg::REQ_RELEASE) && rel_ok;
			ST_SEARCH: begin
				// no warm entry: after a full turn the head is the oldest again
				if (head_warm || step_q == len_q) ctl.remove_head = 1'b1;
				else ctl.rotate = 1'b1;
			end
			ST_REALIGN: ctl.rotate = (rem_q != '0);
			default: ctl = '0;
		endcase
	end

	// in release path without allow_release the chain's append warm comes from the old flag:
	// keep a separate per-region warm store for warmth left unchanged
	logic warm_mem [NUM_REGIONS];
	logic warm_rd_q;
	logic app_w_final;
	assign app_w_final = req_q.allow_release ? !cools_q : warm_rd_q;

	rpa_chain #(.N(NUM_REGIONS), .IW(IW), .LW(LW)) u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.len(len_q),
		.app_index(req_q.region_index),
		.app_warm(app_w_final),
		.head_index(head_index),
		.head_warm(head_warm)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) warm_rd_q <= warm_mem[req.region_index];
		if (state_q == ST_DECIDE && req_q.req_type == rpa_pkg::REQ_RELEASE && rel_ok
			&& req_q.allow_release) begin
			warm_mem[req_q.region_index] <= !cools_q;
		end else if (state_q == ST_DECIDE && req_q.req_type == rpa_pkg::REQ_ACQUIRE
			&& len_q == '0 && can_new) begin
			warm_mem[resv_q[IW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q <= LW'(64);
			cools_q <= 1'b1;
			len_q <= '0;
			resv_q <= '0;
			free_q <= '0;
			c_new_q <= '0;
			c_warm_q <= '0;
			c_cold_q <= '0;
			c_cool_q <= '0;
			c_exh_q <= '0;
			step_q <= '0;
			rem_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rpa_pkg::CFG_MAX_REGIONS: max_q <= cfg_data;
					rpa_pkg::CFG_RELEASE_COOLS: cools_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_DECIDE;
				ST_DECIDE: begin
					step_q <= '0;
					if (req_q.req_type == rpa_pkg::REQ_RELEASE) begin
						state_q <= ST_DONE;
						if (rel_ok) begin
							len_q <= len_q + LW'(1);
							free_q[req_q.region_index] <= 1'b1;
							if (req_q.allow_release && cools_q && c_cool_q != CMAX)
								c_cool_q <= c_cool_q + 1'b1;
						end
					end else if (len_q != '0) begin
						state_q <= ST_SEARCH;
					end else begin
						state_q <= ST_DONE;
						if (can_new) begin
							resv_q <= resv_q + LW'(1);
							if (c_new_q != CMAX) c_new_q <= c_new_q + 1'b1;
						end else if (c_exh_q != CMAX) begin
							c_exh_q <= c_exh_q + 1'b1;
						end
					end
				end
				ST_SEARCH: begin
					if (ctl.remove_head) begin
						free_q[head_index] <= 1'b0;
						len_q <= len_q - LW'(1);
						// entries before the hit went to the back: rotate rest
						rem_q <= (step_q == len_q) ? '0 : len_q - LW'(1) - step_q;
						if (head_warm) begin
							if (c_warm_q != CMAX) c_warm_q <= c_warm_q + 1'b1;
						end else if (c_cold_q != CMAX) begin
							c_cold_q <= c_cold_q + 1'b1;
						end
						state_q <= ST_REALIGN;
					end else begin
						step_q <= step_q + LW'(1);
					end
				end
				ST_REALIGN: begin
					if (rem_q == '0) state_q <= ST_DONE;
					else rem_q <= rem_q - LW'(1);
				end
				ST_DONE: begin
					result_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) req_q <= req;
		if (state_q == ST_DECIDE) begin
			granted_q <= 1'b0;
			gidx_q <= '0;
			if (req_q.req_type == rpa_pkg::REQ_RELEASE) begin
				out_q <= rel_ok ? rpa_pkg::OUT_RELEASED : rpa_pkg::OUT_REJECTED;
			end else if (len_q == '0) begin
				if (can_new) begin
					out_q <= rpa_pkg::OUT_NEW;
					granted_q <= 1'b1;
					gidx_q <= resv_q[IW-1:0];
				end else begin
					out_q <= rpa_pkg::OUT_EXHAUSTED;
				end
			end
		end else if (state_q == ST_SEARCH && ctl.remove_head) begin
			granted_q <= 1'b1;
			gidx_q <= head_index;
			out_q <= head_warm ? rpa_pkg::OUT_WARM_HIT : rpa_pkg::OUT_COLD_HIT;
		end
	end

	always_comb begin
		result = '0;
		result.granted = granted_q;
		result.granted_index = gidx_q;
		result.outcome = out_q;
		result.reserved_count = resv_q;
		result.free_count = len_q;
		result.new_alloc_total = SW'(c_new_q);
		result.warm_hit_total = SW'(c_warm_q);
		result.cold_hit_total = SW'(c_cold_q);
		result.cooled_total = SW'(c_cool_q);
		result.exhausted_total = SW'(c_exh_q);
	end

	`RPA_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`RPA_ASSERT_IMP(a_res_idle, clk, arst_n, result_valid, !busy)
	`RPA_ASSERT_IMP(a_len_le_resv, clk, arst_n, 1'b1, len_q <= resv_q)
	`RPA_ASSERT_IMP(a_grant_out, clk, arst_n, result_valid && result.granted,
		result.outcome == rpa_pkg::OUT_WARM_HIT || result.outcome == rpa_pkg::OUT_COLD_HIT
		|| result.outcome == rpa_pkg::OUT_NEW)
endmodule

>>> tb/sv/region_pool_checker.sv
// checker for the region pool allocator: predicts each request's result and compares
`timescale 1ns / 1ps
module region_pool_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input rpa_pkg::req_t req,
	input logic result_valid,
	input rpa_pkg::result_t result,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data,
	output int errors,
	output int pending
);
	localparam int POOL_SIZE = 64;
	localparam int SW = rpa_pkg::STAT_W;
	localparam int IW = rpa_pkg::IDX_W;
	localparam int CW = rpa_pkg::CNT7_W;
	localparam logic [SW-1:0] STAT_MAX = '1;

	logic warm [POOL_SIZE];
	logic on_free_list [POOL_SIZE];
	logic [IW-1:0] free_list [$];
	logic [CW-1:0] reserved;
	logic [CW-1:0] limit_regions;
	logic cool_on_release;
	logic [SW-1:0] n_new, n_warm, n_cold, n_cooled, n_exhausted;
	rpa_pkg::result_t expected_results [$];

	function automatic logic [SW-1:0] sat_inc(logic [SW-1:0] c);
		return (c == STAT_MAX) ? c : c + 1'b1;
	endfunction

	// grant from the free list at position pos, keeping the order of the rest
	function automatic logic [IW-1:0] take_free(int pos);
		logic [IW-1:0] h;
		h = free_list[pos];
		free_list.delete(pos);
		on_free_list[h] = 1'b0;
		return h;
	endfunction

	function automatic rpa_pkg::result_t predict_request(rpa_pkg::req_t r);
		rpa_pkg::result_t e;
		int found;
		e = '0;
		found = -1;
		if (r.req_type == rpa_pkg::REQ_ACQUIRE) begin
			for (int i = 0; i < free_list.size(); i++) begin
				if (found < 0 && warm[free_list[i]])
					found = i;
			end
			if (found >= 0) begin
				e.granted_index = take_free(found);
				e.granted = 1'b1;
				e.outcome = rpa_pkg::OUT_WARM_HIT;
				n_warm = sat_inc(n_warm);
			end else if (free_list.size() > 0) begin
				e.granted_index = take_free(0);
				e.granted = 1'b1;
				e.outcome = rpa_pkg::OUT_COLD_HIT;
				n_cold = sat_inc(n_cold);
			end else if (reserved >= limit_regions || reserved >= POOL_SIZE) begin
				e.outcome = rpa_pkg::OUT_EXHAUSTED;
				n_exhausted = sat_inc(n_exhausted);
			end else begin
				e.granted_index = reserved[IW-1:0];
				warm[reserved[IW-1:0]] = 1'b1;
				on_free_list[reserved[IW-1:0]] = 1'b0;
				reserved = reserved + 1'b1;
				e.granted = 1'b1;
				e.outcome = rpa_pkg::OUT_NEW;
				n_new = sat_inc(n_new);
			end
		end else begin
			if ({1'b0, r.region_index} >= reserved || on_free_list[r.region_index] ||
				free_list.size() >= POOL_SIZE) begin
				e.outcome = rpa_pkg::OUT_REJECTED;
			end else begin
				free_list.insert(free_list.size(), r.region_index);
				on_free_list[r.region_index] = 1'b1;
				if (r.allow_release) begin
					if (cool_on_release) begin
						warm[r.region_index] = 1'b0;
						n_cooled = sat_inc(n_cooled);
					end else begin
						warm[r.region_index] = 1'b1;
					end
				end
				e.outcome = rpa_pkg::OUT_RELEASED;
			end
		end
		e.reserved_count = reserved;
		e.free_count = CW'(free_list.size());
		e.new_alloc_total = n_new;
		e.warm_hit_total = n_warm;
		e.cold_hit_total = n_cold;
		e.cooled_total = n_cooled;
		e.exhausted_total = n_exhausted;
		return e;
	endfunction

	task automatic check_field(string name, logic [SW-1:0] exp_v, logic [SW-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		rpa_pkg::result_t e;
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				warm[i] = 1'b0;
				on_free_list[i] = 1'b0;
			end
			free_list = {};
			expected_results = {};
			reserved = '0;
			limit_regions = 7'd64;
			cool_on_release = 1'b1;
			{n_new, n_warm, n_cold, n_cooled, n_exhausted} = '0;
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rpa_pkg::CFG_MAX_REGIONS)
					limit_regions = cfg_data;
				else if (cfg_index == rpa_pkg::CFG_RELEASE_COOLS)
					cool_on_release = cfg_data[0];
			end
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, result);
					errors++;
				end else begin
					e = expected_results[0];
					expected_results.delete(0);
					check_field("granted", SW'(e.granted), SW'(result.granted));
					check_field("granted_index", SW'(e.granted_index),
						SW'(result.granted_index));
					check_field("outcome", SW'(e.outcome), SW'(result.outcome));
					check_field("reserved_count", SW'(e.reserved_count),
						SW'(result.reserved_count));
					check_field("free_count", SW'(e.free_count), SW'(result.free_count));
					check_field("new_alloc_total", e.new_alloc_total, result.new_alloc_total);
					check_field("warm_hit_total", e.warm_hit_total, result.warm_hit_total);
					check_field("cold_hit_total", e.cold_hit_total, result.cold_hit_total);
					check_field("cooled_total", e.cooled_total, result.cooled_total);
					check_field("exhausted_total", e.exhausted_total,
						result.exhausted_total);
				end
			end
			if (start && !busy)
				expected_results.insert(expected_results.size(), predict_request(req));
			pending = expected_results.size();
		end
	end
endmodule

>>> tb/sv/tb_region_pool_allocator.sv
// testbench top for the region pool allocator: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_region_pool_allocator;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IW = rpa_pkg::IDX_W;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	rpa_pkg::req_t req;
	logic result_valid;
	rpa_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data;
	int errors;
	int pending;
	int quiet_cycles;
	bit calm;
	logic [rpa_pkg::CNT7_W-1:0] seen_reserved;

	region_pool_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	region_pool_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// stimulus only uses this to aim releases at handles that exist
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_reserved <= '0;
		else if (result_valid)
			seen_reserved <= result.reserved_count;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_region_pool_allocator failed");
				$finish;
			end
		end
	end

	task automatic idle_gap();
		if (!calm && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 7)) @(posedge clk);
	endtask

	task automatic send_request(logic kind, logic [IW-1:0] idx, logic allow);
		idle_gap();
		do @(negedge clk); while (busy);
		@(posedge clk);
		start <= 1'b1;
		req <= '{req_type: kind, region_index: idx, allow_release: allow};
		@(posedge clk);
		start <= 1'b0;
	endtask

	task automatic write_reg(logic [rpa_pkg::CFG_IDX_W-1:0] idx,
		logic [rpa_pkg::CFG_DATA_W-1:0] data);
		// wait until the request in flight has returned its result
		do @(negedge clk); while (busy || pending != 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_request(int acquire_pct);
		logic [IW-1:0] idx;
		if ($urandom_range(0, 99) < acquire_pct) begin
			send_request(rpa_pkg::REQ_ACQUIRE, IW'($urandom), 1'(($urandom)));
		end else begin
			if ($urandom_range(0, 99) < 85 && seen_reserved != 0)
				idx = IW'($urandom_range(0, seen_reserved - 1));
			else
				idx = IW'($urandom_range(0, 63));
			send_request(rpa_pkg::REQ_RELEASE, idx, 1'($urandom));
		end
	endtask

	initial begin
		logic [rpa_pkg::CFG_DATA_W-1:0] limits [6];
		logic cools [6];
		limits = '{7'd64, 7'd0, 7'd3, 7'd127, 7'd1, 7'd64};
		cools = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: new, cooled and warm release, double and unknown release, cold and warm hits, exhaustion
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd63, 1'b1);
		send_request(rpa_pkg::REQ_RELEASE, 6'd0, 1'b1);
		send_request(rpa_pkg::REQ_RELEASE, 6'd0, 1'b1);
		send_request(rpa_pkg::REQ_RELEASE, 6'd63, 1'b0);
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd0, 1'b0);
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd0, 1'b0);
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd0, 1'b0);
		send_request(rpa_pkg::REQ_RELEASE, 6'd2, 1'b1);
		send_request(rpa_pkg::REQ_RELEASE, 6'd1, 1'b0);
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd0, 1'b0);
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd0, 1'b0);
		write_reg(rpa_pkg::CFG_RELEASE_COOLS, 7'd0);
		send_request(rpa_pkg::REQ_RELEASE, 6'd0, 1'b1);
		send_request(rpa_pkg::REQ_RELEASE, 6'd2, 1'b1);
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd0, 1'b0);
		write_reg(rpa_pkg::CFG_MAX_REGIONS, 7'd3);
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd0, 1'b0);
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd0, 1'b0);
		send_request(rpa_pkg::REQ_ACQUIRE, 6'd0, 1'b0);
		send_request(rpa_pkg::REQ_RELEASE, 6'd3, 1'b1);

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(rpa_pkg::CFG_MAX_REGIONS, limits[ph]);
			write_reg(rpa_pkg::CFG_RELEASE_COOLS, 7'(cools[ph]));
			calm = (ph == 5);
			for (int n = 0; n < 72; n++)
				random_request(ph == 3 ? 75 : 55);
		end

		while (pending != 0) @(posedge clk);
		repeat (140) @(posedge clk);
		if (errors == 0)
			$display("tb_region_pool_allocator passed");
		else
			$display("tb_region_pool_allocator failed");
		$finish;
	end
endmodule
